>>> hw/rtl/v3n_pkg.sv
// Shared widths, types and helpers for the vector normalize / axis snap block.
package v3n_pkg;

    localparam int DATA_W  = 32;            // component and result width
    localparam int SQ_W    = 2 * DATA_W;    // squared length width
    localparam int ROOT_W  = SQ_W / 2;      // floor square root width
    localparam int FRAC_W  = 30;            // Q1.30 fraction bits
    localparam int QUOT_W  = FRAC_W + 1;    // quotient magnitude fits in 2^30
    localparam int EPS_W   = 31;
    localparam int LANES   = 3;
    localparam int LAT     = 67;            // request to result, in cycles
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1074);
    localparam logic signed [DATA_W-1:0] ONE_Q30 = DATA_W'(1) <<< FRAC_W;

    typedef struct packed {
        logic [ROOT_W-1:0] len;
        logic              zero;
    } t_meta;

    // {snap to +1, snap to -1}; +1 wins when both hold
    function automatic logic [1:0] snap_dir(input logic signed [DATA_W-1:0] u,
                                            input logic [EPS_W-1:0] eps);
        logic signed [DATA_W+1:0] e;
        logic signed [DATA_W+1:0] dp;
        logic signed [DATA_W+1:0] dm;
        logic                     plus;
        logic                     minus;
        e  = $signed({3'b000, eps});
        dp = (DATA_W+2)'(u) - (DATA_W+2)'(ONE_Q30);
        dm = (DATA_W+2)'(u) + (DATA_W+2)'(ONE_Q30);
        plus  = (dp >= -e) && (dp <= e);
        minus = (dm >= -e) && (dm <= e);
        return {plus, minus && !plus};
    endfunction

endpackage

>>> hw/rtl/v3n_sqrt.sv
// Pipelined floor square root, one root bit per stage, with a tag carried alongside.
module v3n_sqrt #(
    parameter int TAG_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [v3n_pkg::SQ_W-1:0]    i_sq,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_valid,
    output logic [v3n_pkg::ROOT_W-1:0]  o_root,
    output logic [TAG_W-1:0]            o_tag
);
    import v3n_pkg::*;

    localparam int STAGES = ROOT_W;
    localparam int REM_W  = ROOT_W + 1;

    logic              r_vld  [STAGES];
    logic [REM_W-1:0]  r_rem  [STAGES];
    logic [ROOT_W-1:0] r_root [STAGES];
    logic [SQ_W-1:0]   r_n    [STAGES];
    logic [TAG_W-1:0]  r_tag  [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic              vld_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SQ_W-1:0]   n_in;
        logic [TAG_W-1:0]  tag_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              ge;

        if (s == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = i_sq;
            assign tag_in  = i_tag;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign n_in    = r_n[s-1];
            assign tag_in  = r_tag[s-1];
        end

        always_comb begin
            rem_sh = {rem_in, n_in[SQ_W-1 -: 2]};
            trial  = {1'b0, root_in, 2'b01};
            ge     = rem_sh >= trial;
            diff   = rem_sh - trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
            r_rem[s]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            r_root[s] <= {root_in[ROOT_W-2:0], ge};
            r_n[s]    <= {n_in[SQ_W-3:0], 2'b00};
            r_tag[s]  <= tag_in;
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_root  = r_root[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];

endmodule

>>> hw/rtl/v3n_div.sv
// Pipelined restoring divider for one lane: (num << 30) / den, one quotient bit per stage.
module v3n_div #(
    parameter int TAG_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [v3n_pkg::DATA_W-1:0]  i_num,
    input  logic [v3n_pkg::ROOT_W-1:0]  i_den,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_valid,
    output logic [v3n_pkg::QUOT_W-1:0]  o_quot,
    output logic [TAG_W-1:0]            o_tag
);
    import v3n_pkg::*;

    localparam int STAGES = QUOT_W;

    logic              r_vld  [STAGES];
    logic [ROOT_W-1:0] r_rem  [STAGES];
    logic [ROOT_W-1:0] r_den  [STAGES];
    logic [QUOT_W-1:0] r_quot [STAGES];
    logic [QUOT_W-1:0] r_low  [STAGES];
    logic [TAG_W-1:0]  r_tag  [STAGES];

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic              vld_in;
        logic [ROOT_W-1:0] rem_in;
        logic [ROOT_W-1:0] den_in;
        logic [QUOT_W-1:0] quot_in;
        logic [QUOT_W-1:0] low_in;
        logic [TAG_W-1:0]  tag_in;
        logic [ROOT_W:0]   rem_sh;
        logic [ROOT_W:0]   diff;
        logic              ge;

        if (s == 0) begin : g_first
            // upper dividend bits are below den since the quotient fits QUOT_W bits
            assign vld_in  = i_valid;
            assign rem_in  = ROOT_W'(i_num[DATA_W-1:1]);
            assign den_in  = i_den;
            assign quot_in = '0;
            assign low_in  = {i_num[0], {(QUOT_W-1){1'b0}}};
            assign tag_in  = i_tag;
        end else begin : g_next
            assign vld_in  = r_vld[s-1];
            assign rem_in  = r_rem[s-1];
            assign den_in  = r_den[s-1];
            assign quot_in = r_quot[s-1];
            assign low_in  = r_low[s-1];
            assign tag_in  = r_tag[s-1];
        end

        always_comb begin
            rem_sh = {rem_in, low_in[QUOT_W-1]};
            ge     = rem_sh >= {1'b0, den_in};
            diff   = rem_sh - {1'b0, den_in};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= vld_in;
            end
            r_rem[s]  <= ge ? diff[ROOT_W-1:0] : rem_sh[ROOT_W-1:0];
            r_den[s]  <= den_in;
            r_quot[s] <= {quot_in[QUOT_W-2:0], ge};
            r_low[s]  <= {low_in[QUOT_W-2:0], 1'b0};
            r_tag[s]  <= tag_in;
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quot  = r_quot[STAGES-1];
    assign o_tag   = r_tag[STAGES-1];

endmodule

>>> hw/rtl/v3n_merge.sv
// Merge stage: applies signs, picks the first snapping axis, clears the unit for a zero input, registers the result.
module v3n_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [v3n_pkg::QUOT_W-1:0]         i_quot [v3n_pkg::LANES],
    input  logic [v3n_pkg::LANES-1:0]          i_sgn,
    input  v3n_pkg::t_meta                     i_meta,
    input  logic [v3n_pkg::EPS_W-1:0]          i_eps,
    output logic                               o_valid,
    output logic signed [v3n_pkg::DATA_W-1:0]  o_unit [v3n_pkg::LANES],
    output logic [v3n_pkg::ROOT_W-1:0]         o_magnitude,
    output logic                               o_zero_input
);
    import v3n_pkg::*;

    logic signed [DATA_W-1:0] u      [LANES];
    logic [1:0]               dir    [LANES];
    logic signed [DATA_W-1:0] n_unit [LANES];
    logic                     taken;

    logic                     r_valid;
    logic signed [DATA_W-1:0] r_unit [LANES];
    logic [ROOT_W-1:0]        r_mag;
    logic                     r_zero;

    always_comb begin
        taken = 1'b0;
        for (int i = 0; i < LANES; i++) begin
            u[i]   = i_sgn[i] ? -$signed(DATA_W'(i_quot[i])) : $signed(DATA_W'(i_quot[i]));
            dir[i] = snap_dir(u[i], i_eps);
            n_unit[i] = u[i];
        end
        // first axis in x, y, z order that snaps wins, the others clear
        for (int i = 0; i < LANES; i++) begin
            if (!taken && (dir[i] != 2'b00)) begin
                taken = 1'b1;
                for (int j = 0; j < LANES; j++) begin
                    n_unit[j] = '0;
                end
                n_unit[i] = dir[i][1] ? ONE_Q30 : -ONE_Q30;
            end
        end
        if (i_meta.zero) begin
            for (int i = 0; i < LANES; i++) begin
                n_unit[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_unit <= n_unit;
        r_mag  <= i_meta.len;
        r_zero <= i_meta.zero;
    end

    assign o_valid      = r_valid;
    assign o_unit       = r_unit;
    assign o_magnitude  = r_mag;
    assign o_zero_input = r_zero;

endmodule

>>> hw/rtl/vec3_normalize_axis_snap.sv
// Top level: squares, pipelined root, three divider lanes and the snap merge.
// Usage:
//   Pulse i_start with i_vec_x/y/z (signed Q16.16) to issue a request. A request
//   is taken at any rising edge with i_start high and o_busy low; o_busy is low
//   whenever reset is released, so one request may be issued every cycle.
//   Each result appears for one cycle with o_valid high: o_unit_x/y/z
//   (signed Q1.30), o_magnitude (Q16.16), o_zero_input.
//   Pipeline, in order: input/abs, squares, sum, root (one bit per stage),
//   divide (one quotient bit per stage, three lanes side by side), snap merge.
//   Throughput: one request per cycle, set by the fully pipelined root and
//   divider stages.
//   The receiver cannot stall; results must be taken in the cycle they show.
//   Snap tolerance: write i_cfg_wdata with i_cfg_we, only while no request is in
//   flight. Reset (synchronous, active low) sets it to 1074 and drops every
//   request in flight.
module vec3_normalize_axis_snap (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [v3n_pkg::DATA_W-1:0]  i_vec_x,
    input  logic signed [v3n_pkg::DATA_W-1:0]  i_vec_y,
    input  logic signed [v3n_pkg::DATA_W-1:0]  i_vec_z,
    input  logic                               i_cfg_we,
    input  logic [v3n_pkg::EPS_W-1:0]          i_cfg_wdata,
    output logic                               o_valid,
    output logic signed [v3n_pkg::DATA_W-1:0]  o_unit_x,
    output logic signed [v3n_pkg::DATA_W-1:0]  o_unit_y,
    output logic signed [v3n_pkg::DATA_W-1:0]  o_unit_z,
    output logic [v3n_pkg::ROOT_W-1:0]         o_magnitude,
    output logic                               o_zero_input
);
    import v3n_pkg::*;

    localparam int STAG_W = LANES * DATA_W + LANES + 1;
    localparam int MTAG_W = $bits(t_meta) + 1;

    logic [EPS_W-1:0]  r_eps;

    logic              r_a_vld;
    logic [DATA_W-1:0] r_a_abs [LANES];
    logic [LANES-1:0]  r_a_sgn;
    logic              r_b_vld;
    logic [SQ_W-1:0]   r_b_sq  [LANES];
    logic [DATA_W-1:0] r_b_abs [LANES];
    logic [LANES-1:0]  r_b_sgn;
    logic              r_c_vld;
    logic [SQ_W-1:0]   r_c_sum;
    logic [DATA_W-1:0] r_c_abs [LANES];
    logic [LANES-1:0]  r_c_sgn;
    logic              r_c_zero;

    logic signed [DATA_W-1:0] vec_in [LANES];
    logic                     accept;

    logic [STAG_W-1:0] s_tag_in;
    logic [STAG_W-1:0] s_tag_out;
    logic              s_vld;
    logic [ROOT_W-1:0] s_root;
    logic [DATA_W-1:0] s_abs [LANES];
    logic [LANES-1:0]  s_sgn;
    logic              s_zero;
    t_meta             s_meta;

    logic              d_vld  [LANES];
    logic [QUOT_W-1:0] d_quot [LANES];
    logic [MTAG_W-1:0] d_tag0;
    logic              d_sgn  [LANES];
    t_meta             d_meta;

    logic signed [DATA_W-1:0] m_unit [LANES];

    assign o_busy   = !i_rst_n;
    assign accept   = i_start && !o_busy;
    assign vec_in[0] = i_vec_x;
    assign vec_in[1] = i_vec_y;
    assign vec_in[2] = i_vec_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps   <= EPS_RESET;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_eps <= i_cfg_wdata;
            end
            r_a_vld <= accept;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
        for (int i = 0; i < LANES; i++) begin
            r_a_abs[i] <= vec_in[i][DATA_W-1] ? DATA_W'(-vec_in[i]) : DATA_W'(vec_in[i]);
            r_a_sgn[i] <= vec_in[i][DATA_W-1];
            r_b_sq[i]  <= SQ_W'(r_a_abs[i]) * SQ_W'(r_a_abs[i]);
        end
        r_b_abs  <= r_a_abs;
        r_b_sgn  <= r_a_sgn;
        // three squares of at most 2^62 each never carry out of 64 bits
        r_c_sum  <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        r_c_zero <= (r_b_sq[0] == '0) && (r_b_sq[1] == '0) && (r_b_sq[2] == '0);
        r_c_abs  <= r_b_abs;
        r_c_sgn  <= r_b_sgn;
    end

    assign s_tag_in = {r_c_abs[0], r_c_abs[1], r_c_abs[2], r_c_sgn, r_c_zero};

    v3n_sqrt #(.TAG_W(STAG_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c_vld),
        .i_sq    (r_c_sum),
        .i_tag   (s_tag_in),
        .o_valid (s_vld),
        .o_root  (s_root),
        .o_tag   (s_tag_out)
    );

    assign {s_abs[0], s_abs[1], s_abs[2], s_sgn, s_zero} = s_tag_out;
    assign s_meta = {s_root, s_zero};

    v3n_div #(.TAG_W(MTAG_W)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_vld),
        .i_num   (s_abs[0]),
        .i_den   (s_root),
        .i_tag   ({s_meta, s_sgn[0]}),
        .o_valid (d_vld[0]),
        .o_quot  (d_quot[0]),
        .o_tag   (d_tag0)
    );

    v3n_div #(.TAG_W(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_vld),
        .i_num   (s_abs[1]),
        .i_den   (s_root),
        .i_tag   (s_sgn[1]),
        .o_valid (d_vld[1]),
        .o_quot  (d_quot[1]),
        .o_tag   (d_sgn[1])
    );

    v3n_div #(.TAG_W(1)) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_vld),
        .i_num   (s_abs[2]),
        .i_den   (s_root),
        .i_tag   (s_sgn[2]),
        .o_valid (d_vld[2]),
        .o_quot  (d_quot[2]),
        .o_tag   (d_sgn[2])
    );

    // lane x carries the length and zero flag alongside its sign
    assign {d_meta, d_sgn[0]} = d_tag0;

    v3n_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (d_vld[0]),
        .i_quot       (d_quot),
        .i_sgn        ({d_sgn[2], d_sgn[1], d_sgn[0]}),
        .i_meta       (d_meta),
        .i_eps        (r_eps),
        .o_valid      (o_valid),
        .o_unit       (m_unit),
        .o_magnitude  (o_magnitude),
        .o_zero_input (o_zero_input)
    );

    assign o_unit_x = m_unit[0];
    assign o_unit_y = m_unit[1];
    assign o_unit_z = m_unit[2];

`ifndef ASSERT_OFF
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d_vld[0] == d_vld[1]) && (d_vld[1] == d_vld[2]))
        else $error("divider lanes out of step");

    a_zero_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_input) |->
        (o_unit_x == '0) && (o_unit_y == '0) && (o_unit_z == '0) && (o_magnitude == '0))
        else $error("zero vector gave nonzero result");

    a_nonzero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_zero_input) |-> (o_magnitude != '0))
        else $error("nonzero vector with zero length");

    a_snap_x_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && ((o_unit_x == ONE_Q30) || (o_unit_x == -ONE_Q30))) |->
        (o_unit_y == '0) && (o_unit_z == '0))
        else $error("x at unit length but other axes not cleared");

    a_cfg_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_a_vld) |-> ##(LAT-1) o_valid)
        else $error("result latency mismatch");
`endif

endmodule

>>> sim/tb.sv
// Testbench for vec3_normalize_axis_snap: directed table, random vectors and predictor checks.
`timescale 1ns / 100ps

module tb;
    import v3n_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] ux;
        logic signed [DATA_W-1:0] uy;
        logic signed [DATA_W-1:0] uz;
        logic [ROOT_W-1:0]        mag;
        logic                     zero;
    } t_norm;

    typedef struct {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        bit                       typed;
        t_norm                    res;
    } t_row;

    localparam int WDOG_LIMIT = 2000;
    localparam int N_RANDOM   = 400;
    localparam logic [EPS_W-1:0] EPS_MAX_RANGE = EPS_W'(1073741824);

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic                     o_busy;
    logic signed [DATA_W-1:0] i_vec_x = '0;
    logic signed [DATA_W-1:0] i_vec_y = '0;
    logic signed [DATA_W-1:0] i_vec_z = '0;
    logic                     i_cfg_we = 1'b0;
    logic [EPS_W-1:0]         i_cfg_wdata = '0;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_unit_x;
    logic signed [DATA_W-1:0] o_unit_y;
    logic signed [DATA_W-1:0] o_unit_z;
    logic [ROOT_W-1:0]        o_magnitude;
    logic                     o_zero_input;

    t_norm            norm_q[$];
    logic [EPS_W-1:0] eps_shadow = EPS_RESET;
    int               err_cnt = 0;
    int               idle_pct = 0;
    int               quiet_cycles = 0;
    bit               accepted_now = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    vec3_normalize_axis_snap u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_unit_x    (o_unit_x),
        .o_unit_y    (o_unit_y),
        .o_unit_z    (o_unit_z),
        .o_magnitude (o_magnitude),
        .o_zero_input(o_zero_input)
    );

    // squared length wraps mod 2^64 just like the hardware sum
    function automatic t_norm normalize_vec(input logic signed [DATA_W-1:0] x,
                                            input logic signed [DATA_W-1:0] y,
                                            input logic signed [DATA_W-1:0] z,
                                            input logic [EPS_W-1:0] eps);
        longint     comp[3];
        logic [63:0] mag_abs;
        logic [63:0] sum;
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        longint     u[3];
        longint     e;
        logic [63:0] q;
        int         dir;
        t_norm      r;
        comp[0] = x;
        comp[1] = y;
        comp[2] = z;
        sum = '0;
        u[0] = 0;
        u[1] = 0;
        u[2] = 0;
        root = '0;
        e = longint'(eps);
        for (int i = 0; i < LANES; i++) begin
            mag_abs = comp[i] < 0 ? -comp[i] : comp[i];
            sum = sum + mag_abs * mag_abs;
        end
        if (sum != 0) begin
            rem = sum;
            bitv = 64'd1 << 62;
            while (bitv > sum) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            for (int i = 0; i < LANES; i++) begin
                mag_abs = comp[i] < 0 ? -comp[i] : comp[i];
                q = (mag_abs << FRAC_W) / root;
                u[i] = comp[i] < 0 ? -longint'(q) : longint'(q);
                dir = 0;
                if (longint'(ONE_Q30) - e <= u[i] && u[i] <= longint'(ONE_Q30) + e)
                    dir = 1;
                else if (-longint'(ONE_Q30) - e <= u[i] && u[i] <= -longint'(ONE_Q30) + e)
                    dir = -1;
                if (dir != 0) begin
                    for (int j = 0; j < LANES; j++) u[j] = 0;
                    u[i] = dir > 0 ? longint'(ONE_Q30) : -longint'(ONE_Q30);
                    break;
                end
            end
        end
        r.ux = u[0][DATA_W-1:0];
        r.uy = u[1][DATA_W-1:0];
        r.uz = u[2][DATA_W-1:0];
        r.mag = root[ROOT_W-1:0];
        r.zero = (sum == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        $display("mismatch %s: got %h expected %h at %0t", field, got, exp_val, $realtime);
        err_cnt++;
    endtask

    task automatic issue_vec(input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y,
                             input logic signed [DATA_W-1:0] z,
                             input bit typed, input t_norm typed_res);
        @(negedge i_clk);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_vec_x <= x;
        i_vec_y <= y;
        i_vec_z <= z;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        norm_q.push_back(typed ? typed_res : normalize_vec(x, y, z, eps_shadow));
        accepted_now = 1'b1;
    endtask

    task automatic write_eps(input logic [EPS_W-1:0] val);
        @(negedge i_clk);
        i_start <= 1'b0;
        while (norm_q.size() != 0) @(negedge i_clk);
        repeat (LANES + 70) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        eps_shadow = val;
    endtask

    function automatic logic signed [DATA_W-1:0] rand_comp(input int mode);
        case (mode)
            0: rand_comp = $urandom;
            1: rand_comp = $signed(DATA_W'($urandom_range(65535))) - 32768;
            2: rand_comp = $urandom_range(1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
            default: rand_comp = $signed(DATA_W'($urandom_range(15))) - 8;
        endcase
    endfunction

    task automatic random_block(input int count);
        logic signed [DATA_W-1:0] c[3];
        int axis;
        int shape;
        t_norm dummy;
        dummy = '{default: '0};
        for (int n = 0; n < count; n++) begin
            shape = $urandom_range(9);
            if (shape < 4) begin
                // one dominant component, the rest tiny: exercises the axis snap
                axis = $urandom_range(2);
                for (int i = 0; i < LANES; i++) c[i] = rand_comp(3);
                c[axis] = rand_comp($urandom_range(1) ? 0 : 2);
            end else begin
                for (int i = 0; i < LANES; i++) c[i] = rand_comp($urandom_range(2));
            end
            issue_vec(c[0], c[1], c[2], 1'b0, dummy);
        end
    endtask

    always @(posedge i_clk) begin
        t_norm e;
        if (o_valid) begin
            if (norm_q.size() == 0) begin
                $display("unexpected result at %0t", $realtime);
                err_cnt++;
            end else begin
                e = norm_q.pop_front();
                if (o_unit_x !== e.ux) report_mismatch("unit_x", o_unit_x, e.ux);
                if (o_unit_y !== e.uy) report_mismatch("unit_y", o_unit_y, e.uy);
                if (o_unit_z !== e.uz) report_mismatch("unit_z", o_unit_z, e.uz);
                if (o_magnitude !== e.mag) report_mismatch("magnitude", o_magnitude, e.mag);
                if (o_zero_input !== e.zero) report_mismatch("zero_input", o_zero_input, e.zero);
            end
        end
    end

    always @(posedge i_clk) begin
        #0.1;
        if (accepted_now || o_valid || !i_rst_n || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        accepted_now = 1'b0;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_row  rows[$];
        t_norm none;
        none = '{default: '0};
        rows.push_back('{0, 0, 0, 1'b1, '{0, 0, 0, 0, 1'b1}});
        rows.push_back('{1, 0, 0, 1'b1, '{ONE_Q30, 0, 0, 1, 1'b0}});
        rows.push_back('{0, -1, 0, 1'b1, '{0, -ONE_Q30, 0, 1, 1'b0}});
        rows.push_back('{0, 0, 32'sh7fff_ffff, 1'b1, '{0, 0, ONE_Q30, 32'h7fff_ffff, 1'b0}});
        rows.push_back('{32'sh8000_0000, 0, 0, 1'b1,
                         '{-ONE_Q30, 0, 0, 32'h8000_0000, 1'b0}});
        rows.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, none});
        rows.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, none});
        rows.push_back('{32'sh8000_0000, 32'sh7fff_ffff, 0, 1'b0, none});
        rows.push_back('{1, 1, 1, 1'b0, none});
        rows.push_back('{3, 4, 0, 1'b0, none});
        rows.push_back('{-3, 0, 4, 1'b0, none});
        rows.push_back('{65536, 65536, -65536, 1'b0, none});
        rows.push_back('{100000, 1, -1, 1'b0, none});
        rows.push_back('{-1, 2, 2, 1'b0, none});
        rows.push_back('{0, 12345678, -12345678, 1'b0, none});
        rows.push_back('{-7, -7, 1, 1'b0, none});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset tolerance first, then the table again at the extremes
        foreach (rows[k]) issue_vec(rows[k].x, rows[k].y, rows[k].z, rows[k].typed, rows[k].res);
        write_eps('0);
        foreach (rows[k]) issue_vec(rows[k].x, rows[k].y, rows[k].z, 1'b0, none);
        write_eps(EPS_MAX_RANGE);
        foreach (rows[k]) issue_vec(rows[k].x, rows[k].y, rows[k].z, 1'b0, none);
        write_eps(EPS_W'(32'h7fff_ffff));
        for (int k = 5; k < 9; k++) issue_vec(rows[k].x, rows[k].y, rows[k].z, 1'b0, none);

        idle_pct = 13;
        write_eps(EPS_RESET);
        random_block(N_RANDOM / 4);
        write_eps(EPS_W'($urandom_range(1 << 20)));
        random_block(N_RANDOM / 4);
        idle_pct = 82;
        write_eps(EPS_W'($urandom_range(32'h4000_0000)));
        random_block(N_RANDOM / 4);
        idle_pct = 0;
        write_eps(EPS_W'($urandom_range(4096)));
        random_block(N_RANDOM / 4);

        @(negedge i_clk);
        i_start <= 1'b0;
        while (norm_q.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
